FILE: hw/rtl/fla_pkg.sv
// Shared types and constants for the flush-largest aggregator.
// Used by fla_ctrl, fla_dp and flush_largest_aggregator_top; no dependencies.
`default_nettype none

package fla_pkg;

  localparam int NUM_DEST_DEF = 16;
  localparam int MAX_AGG_DEF  = 64;

  localparam int DEST_W    = 4;   // dest / flush_dest field
  localparam int WORDS_W   = 4;   // item_words / flush_words field
  localparam int CNT_W     = 7;   // pending counts, total, flush_count
  localparam int LIM_W     = 7;   // agg_limit register
  localparam int STAMP_W   = 32;  // tie-break stamps
  localparam int PROD_W    = CNT_W + WORDS_W;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(64);

  localparam logic OP_ENQ       = 1'b0;
  localparam logic OP_FLUSH_ALL = 1'b1;

  localparam logic KIND_THRESH = 1'b0;
  localparam logic KIND_ALL    = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ENQ   = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_PICK  = 6'b001000,
    ST_PUT   = 6'b010000,
    ST_FALL  = 6'b100000
  } state_t;

  typedef struct packed {
    logic capture;     // latch input transfer
    logic use_dest;    // counter read address from captured dest
    logic enq;         // apply enqueue update
    logic scan_start;  // clear scan index and scan accumulators
    logic idx_inc;     // advance scan index
    logic pick_step;   // fold current entry into largest/stamp search
    logic emit_pick;   // emit threshold flush and clear picked entry
    logic emit_all;    // emit flush-all result for current entry
    logic all_done;    // clear total and largest after flush-all
  } cmd_t;

  typedef struct packed {
    logic in_all;      // opcode of the offered input item is flush-all
    logic dest_ok;     // captured dest addresses a real destination
    logic trigger;     // threshold reached after enqueue
    logic idx_last;    // scan index at last destination
    logic rd_nz;       // count at scan index is nonzero
    logic out_free;    // output register can take a result this cycle
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fla_ctrl.sv
// Sequencer for the flush-largest aggregator.
// Depends on fla_pkg; drives fla_dp through cmd_t and reads stat_t.
`default_nettype none

module fla_ctrl
  import fla_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  input  wire stat_t st,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          if (st.in_all == OP_FLUSH_ALL) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_FALL;
          end else begin
            state_nxt = ST_ENQ;
          end
        end
      end
      ST_ENQ: begin
        cmd.use_dest = 1'b1;
        if (st.dest_ok) begin
          cmd.enq   = 1'b1;
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (st.trigger) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_PICK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PICK: begin
        cmd.pick_step = 1'b1;
        cmd.idx_inc   = 1'b1;
        if (st.idx_last) begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (st.out_free) begin
          cmd.emit_pick = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FALL: begin
        // zero entries are skipped; nonzero ones wait for a free output slot
        if (!st.rd_nz || st.out_free) begin
          cmd.emit_all = st.rd_nz;
          cmd.idx_inc  = 1'b1;
          if (st.idx_last) begin
            cmd.all_done = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fla_dp.sv
// Datapath of the flush-largest aggregator: counters, stamps, scan unit, output register.
// Depends on fla_pkg; steered by fla_ctrl through cmd_t.
`default_nettype none

module fla_dp
  import fla_pkg::*;
#(
  parameter int NUM_DEST = NUM_DEST_DEF,
  parameter int MAX_AGG  = MAX_AGG_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output stat_t                      st,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tuser,
  input  wire logic                  cfg_valid,
  input  wire logic [LIM_W-1:0]      cfg_data,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);

  localparam int IDX_W = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_DEST - 1);

  logic [CNT_W-1:0]   cnt_r   [NUM_DEST];
  logic [STAMP_W-1:0] stamp_r [NUM_DEST];
  logic [NUM_DEST-1:0] nz_r;
  logic [CNT_W-1:0]   total_r, largest_r;
  logic [STAMP_W-1:0] clock_r;
  logic [LIM_W-1:0]   limit_r;

  logic [DEST_W-1:0]  dest_r;
  logic [WORDS_W-1:0] words_r;

  logic [IDX_W-1:0]   idx_r, pick_r;
  logic               found_r, multi_r;
  logic [STAMP_W-1:0] best_r;
  logic [CNT_W-1:0]   below_r;

  logic               out_valid_r, out_kind_r, out_last_r;
  logic [DEST_W-1:0]  out_dest_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic [WORDS_W-1:0] out_words_r;

  logic [IDX_W-1:0]   dest_idx, rd_idx;
  logic [CNT_W-1:0]   rd_cnt, cnt_inc;
  logic [STAMP_W-1:0] clock_inc;
  logic [LIM_W-1:0]   lim_eff;
  logic [PROD_W-1:0]  prod;
  logic               rd_eq, later_nz, out_free;
  logic [NUM_DEST-1:0] nz_above;

  assign dest_idx  = IDX_W'(dest_r);
  assign rd_idx    = cmd.use_dest ? dest_idx : idx_r;
  assign rd_cnt    = cnt_r[rd_idx];
  assign cnt_inc   = rd_cnt + CNT_W'(1);
  assign clock_inc = clock_r + STAMP_W'(1);
  assign rd_eq     = (rd_cnt == largest_r) && (rd_cnt != '0);

  // entries above the scan index still holding items
  assign nz_above  = (nz_r >> idx_r) >> 1;
  assign later_nz  = |nz_above;

  // limit clamped to 1..MAX_AGG
  always_comb begin
    priority if (limit_r == '0) begin
      lim_eff = LIM_W'(1);
    end else if (32'(limit_r) > 32'(MAX_AGG)) begin
      lim_eff = LIM_W'(MAX_AGG);
    end else begin
      lim_eff = limit_r;
    end
  end

  assign prod     = PROD_W'(total_r) * PROD_W'(words_r);
  assign out_free = !out_valid_r || out_tready;

  assign st.in_all   = in_tuser;
  assign st.dest_ok  = (32'(dest_r) < 32'(NUM_DEST));
  assign st.trigger  = (prod >= PROD_W'(lim_eff)) || (total_r >= CNT_W'(lim_eff));
  assign st.idx_last = (idx_r == IDX_LAST);
  assign st.rd_nz    = (rd_cnt != '0);
  assign st.out_free = out_free;

  // configuration and input capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dest_r  <= in_tdata[DEST_W-1:0];
      words_r <= in_tdata[DEST_W +: WORDS_W];
    end
  end

  // pending state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DEST; i++) begin
        cnt_r[i]   <= '0;
        stamp_r[i] <= '0;
      end
      nz_r      <= '0;
      total_r   <= '0;
      largest_r <= '0;
      clock_r   <= '0;
    end else begin
      priority if (cmd.enq) begin
        cnt_r[dest_idx]   <= cnt_inc;
        stamp_r[dest_idx] <= clock_inc;
        nz_r[dest_idx]    <= 1'b1;
        total_r           <= total_r + CNT_W'(1);
        clock_r           <= clock_inc;
        if (cnt_inc > largest_r) begin
          largest_r <= cnt_inc;
        end
      end else if (cmd.emit_pick) begin
        cnt_r[pick_r] <= '0;
        nz_r[pick_r]  <= 1'b0;
        total_r       <= (total_r >= largest_r) ? total_r - largest_r : '0;
        largest_r     <= multi_r ? largest_r : below_r;
      end else if (cmd.emit_all || cmd.all_done) begin
        cnt_r[idx_r] <= '0;
        nz_r[idx_r]  <= 1'b0;
        if (cmd.all_done) begin
          total_r   <= '0;
          largest_r <= '0;
        end
      end else begin
      end
    end
  end

  // scan unit: index, tie-break search, runner-up tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      found_r <= 1'b0;
      multi_r <= 1'b0;
    end else if (cmd.scan_start) begin
      idx_r   <= '0;
      found_r <= 1'b0;
      multi_r <= 1'b0;
      below_r <= '0;
    end else begin
      if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.pick_step) begin
        if (rd_eq) begin
          if (!found_r || (stamp_r[idx_r] > best_r)) begin
            pick_r <= idx_r;
            best_r <= stamp_r[idx_r];
          end
          found_r <= 1'b1;
          if (found_r) begin
            multi_r <= 1'b1;
          end
        end else if (rd_cnt > below_r) begin
          below_r <= rd_cnt;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit_pick || cmd.emit_all) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pick) begin
      out_dest_r  <= DEST_W'(pick_r);
      out_cnt_r   <= largest_r;
      out_words_r <= words_r;
      out_kind_r  <= KIND_THRESH;
      out_last_r  <= 1'b1;
    end else if (cmd.emit_all) begin
      out_dest_r  <= DEST_W'(idx_r);
      out_cnt_r   <= rd_cnt;
      out_words_r <= words_r;
      out_kind_r  <= KIND_ALL;
      out_last_r  <= !later_nz;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - DEST_W - CNT_W - WORDS_W)'(0),
                       out_words_r, out_cnt_r, out_dest_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/flush_largest_aggregator_top.sv
// Top level of the flush-largest aggregator message-flush policy.
// Depends on fla_pkg, fla_ctrl and fla_dp.
//
// Usage:
//  - in_*: one transfer per command. tuser is the opcode (enqueue or flush-all);
//    tdata carries dest and item_words. Commands are taken one at a time:
//    in_tready is high only while the sequencer is idle.
//  - out_*: flush results. tuser is the flush kind, tlast marks the final
//    result of a command. A one-entry output register holds each result.
//  - cfg_*: write of agg_limit, always ready; write only while idle.
// Steps per command:
//  - enqueue, no flush: accept, counter update, threshold test.
//  - enqueue with threshold flush: the same steps, then the largest-count
//    search walks the counter bank one destination per cycle.
//  - flush-all: accept, then one destination per cycle, except that a nonzero
//    result waits while the receiver stalls the output register.
// A stalled receiver holds the output register; the sequencer waits on the
// next result. Reset (synchronous, rst_n low) clears all counts, stamps,
// totals and sets agg_limit to 64; no clearing pass is needed.
`default_nettype none

module flush_largest_aggregator_top
  import fla_pkg::*;
#(
  parameter int NUM_DEST = NUM_DEST_DEF,
  parameter int MAX_AGG  = MAX_AGG_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [3:0] dest, [7:4] item_words
  input  wire logic                  in_tuser,   // opcode
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [LIM_W-1:0]      cfg_data,   // agg_limit
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [3:0] flush_dest, [10:4] flush_count,
                                                 // [14:11] flush_words, [15] zero
  output logic                       out_tuser,  // flush_kind
  output logic                       out_tlast   // last
);

  cmd_t  cmd;
  stat_t st;

  // limit register takes a write in any cycle
  assign cfg_ready = 1'b1;

  fla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  fla_dp #(
    .NUM_DEST (NUM_DEST),
    .MAX_AGG  (MAX_AGG)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
